// ===== hdl/ipac_pkg.sv =====
`default_nettype none

package ipac_pkg;

  localparam int unsigned LANES     = 8;
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned DATA_W    = 64;

  localparam logic [2:0] REG_KEY_HIGH   = 3'd0;
  localparam logic [2:0] REG_KEY_LOW    = 3'd1;
  localparam logic [2:0] REG_DECIPHER   = 3'd2;
  localparam logic [2:0] REG_FILTER     = 3'd3;
  localparam logic [2:0] REG_SVC_PORT   = 3'd4;
  localparam logic [2:0] REG_REPEATS    = 3'd5;
  localparam logic [2:0] REG_IPV6_EN    = 3'd6;

  localparam logic [15:0] SVC_PORT_RST  = 16'd53;
  localparam logic [15:0] REPEATS_RST   = 16'd1;

  localparam logic [1:0] FAM_IPV4       = 2'd1;
  localparam logic [1:0] FAM_IPV6       = 2'd2;

  localparam int unsigned FILT_CLIENT   = 0;
  localparam int unsigned FILT_SERVER   = 1;

  localparam logic [1:0] STEP_LAST      = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic [1:0]  src_family;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [15:0] src_port;
    logic [1:0]  dst_family;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] dst_port;
  } req_t;

  typedef struct packed {
    logic        src_changed;
    logic [63:0] src_out_high;
    logic [63:0] src_out_low;
    logic        dst_changed;
    logic [63:0] dst_out_high;
    logic [63:0] dst_out_low;
  } rsp_t;

  typedef struct packed {
    logic        load;
    logic        en;
    logic        decipher;
    logic        last;
    logic [31:0] key_round;
    logic [31:0] key_final;
  } lane_ctrl_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] service_port;
    logic        ipv6_en;
  } filt_t;

  function automatic logic [7:0] rot8(input logic [7:0] v, input int unsigned r);
    logic [15:0] d;
    d = {v, v} << r;
    return d[15:8];
  endfunction

  function automatic logic [31:0] perm_fwd(input logic [31:0] w);
    logic [7:0] s0, s1, s2, s3;
    s0 = w[31:24];
    s1 = w[23:16];
    s2 = w[15:8];
    s3 = w[7:0];
    s0 = s0 + s1;
    s2 = s2 + s3;
    s1 = rot8(s1, 2) ^ s0;
    s3 = rot8(s3, 5) ^ s2;
    s0 = rot8(s0, 4) + s3;
    s2 = s2 + s1;
    s1 = rot8(s1, 3) ^ s2;
    s3 = rot8(s3, 7) ^ s0;
    s2 = rot8(s2, 4);
    return {s0, s1, s2, s3};
  endfunction

  function automatic logic [31:0] perm_bwd(input logic [31:0] w);
    logic [7:0] s0, s1, s2, s3;
    s0 = w[31:24];
    s1 = w[23:16];
    s2 = w[15:8];
    s3 = w[7:0];
    s2 = rot8(s2, 4);
    s1 = s1 ^ s2;
    s3 = s3 ^ s0;
    s1 = rot8(s1, 5);
    s3 = rot8(s3, 1);
    s0 = s0 - s3;
    s2 = s2 - s1;
    s0 = rot8(s0, 4);
    s1 = s1 ^ s0;
    s3 = s3 ^ s2;
    s1 = rot8(s1, 6);
    s3 = rot8(s3, 3);
    s0 = s0 - s1;
    s2 = s2 - s3;
    return {s0, s1, s2, s3};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ipac_lane.sv =====
`default_nettype none

module ipac_lane (
  input  wire                     clk_i,
  input  wire ipac_pkg::lane_ctrl_t ctrl_i,
  input  wire logic [31:0]        blk_i,
  output logic [31:0]             blk_o
);

  logic [31:0] blk_q, blk_d;
  logic [31:0] mixed, permuted;

  always_comb begin
    mixed    = blk_q ^ ctrl_i.key_round;
    permuted = ctrl_i.decipher ? ipac_pkg::perm_bwd(mixed) : ipac_pkg::perm_fwd(mixed);
    blk_d    = ctrl_i.last ? (permuted ^ ctrl_i.key_final) : permuted;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      blk_q <= blk_i;
    end else if (ctrl_i.en) begin
      blk_q <= blk_d;
    end
  end

  assign blk_o = blk_q;

endmodule

`default_nettype wire

// ===== hdl/ipac_merge.sv =====
`default_nettype none

module ipac_merge (
  input  wire ipac_pkg::req_t                          req_i,
  input  wire ipac_pkg::filt_t                         filt_i,
  input  wire logic [ipac_pkg::LANES-1:0][31:0]        lanes_i,
  output ipac_pkg::rsp_t                               rsp_o
);

  typedef struct packed {
    logic        changed;
    logic [63:0] hi;
    logic [63:0] lo;
  } addr_res_t;

  function automatic addr_res_t merge_addr(
    input logic [1:0]       fam,
    input logic [63:0]      hi,
    input logic [63:0]      lo,
    input logic [15:0]      port,
    input logic [3:0][31:0] blk,
    input ipac_pkg::filt_t  filt
  );
    addr_res_t  res;
    logic       skip;
    logic       do_v4;
    logic       do_v6;
    skip  = (filt.mode[ipac_pkg::FILT_CLIENT] && (port == filt.service_port)) ||
            (filt.mode[ipac_pkg::FILT_SERVER] && (port != filt.service_port));
    do_v4 = !skip && (fam == ipac_pkg::FAM_IPV4);
    do_v6 = !skip && (fam == ipac_pkg::FAM_IPV6) && filt.ipv6_en;
    res.changed = do_v4 || do_v6;
    res.hi      = do_v6 ? {blk[0], blk[1]} : hi;
    if (do_v6) begin
      res.lo = {blk[2], blk[3]};
    end else if (do_v4) begin
      res.lo = {lo[63:32], blk[3]};
    end else begin
      res.lo = lo;
    end
    return res;
  endfunction

  addr_res_t src_res, dst_res;

  always_comb begin
    src_res = merge_addr(req_i.src_family, req_i.src_addr_high, req_i.src_addr_low,
                         req_i.src_port, lanes_i[3:0], filt_i);
    dst_res = merge_addr(req_i.dst_family, req_i.dst_addr_high, req_i.dst_addr_low,
                         req_i.dst_port, lanes_i[7:4], filt_i);
    rsp_o.src_changed  = src_res.changed;
    rsp_o.src_out_high = src_res.hi;
    rsp_o.src_out_low  = src_res.lo;
    rsp_o.dst_changed  = dst_res.changed;
    rsp_o.dst_out_high = dst_res.hi;
    rsp_o.dst_out_low  = dst_res.lo;
  end

endmodule

`default_nettype wire

// ===== hdl/ip_address_cipher_filter.sv =====
// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_stall_o    in_req_i   (ipac_pkg::req_t)
// response  out        out_valid_o / out_stall_i  out_rsp_o  (ipac_pkg::rsp_t)
// config    in         psel/penable/pwrite        paddr, pwdata, prdata (64 bit)
//
// A request is loaded into eight parallel lanes, which run one cipher round
// per cycle (three rounds per pass, R = round_repeats passes); the result is
// merged into the response register.
// Reset clears control and restores the register defaults.
// The response register frees the core, so a new request is taken while
// a response is stalled; the core waits in its merge cycle only if the
// previous response is still held.
`default_nettype none

module ip_address_cipher_filter (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire ipac_pkg::req_t               in_req_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output ipac_pkg::rsp_t                    out_rsp_o,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire logic [ipac_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ipac_pkg::DATA_W-1:0]  pwdata,
  output logic [ipac_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  logic [63:0] key_high_q, key_low_q;
  logic        decipher_q;
  logic [1:0]  filt_mode_q;
  logic [15:0] svc_port_q;
  logic [15:0] repeats_q;
  logic        ipv6_en_q;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  ipac_pkg::state_e state_q, state_d;
  logic [1:0]  step_q, step_d;
  logic [15:0] pass_q, pass_d;
  logic        in_acc;
  logic        load_out;
  logic        run_done;

  ipac_pkg::req_t      req_q;
  ipac_pkg::rsp_t      merged;
  ipac_pkg::rsp_t      out_rsp_q;
  logic                out_valid_q, out_valid_d;
  ipac_pkg::lane_ctrl_t lane_ctrl;
  ipac_pkg::filt_t      filt;
  logic [ipac_pkg::LANES-1:0][31:0] lane_in;
  logic [ipac_pkg::LANES-1:0][31:0] lane_out;
  logic [3:0][31:0] kw;

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q  <= '0;
      key_low_q   <= '0;
      decipher_q  <= 1'b0;
      filt_mode_q <= 2'd0;
      svc_port_q  <= ipac_pkg::SVC_PORT_RST;
      repeats_q   <= ipac_pkg::REPEATS_RST;
      ipv6_en_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ipac_pkg::REG_KEY_HIGH: key_high_q  <= pwdata;
        ipac_pkg::REG_KEY_LOW:  key_low_q   <= pwdata;
        ipac_pkg::REG_DECIPHER: decipher_q  <= pwdata[0];
        ipac_pkg::REG_FILTER:   filt_mode_q <= pwdata[1:0];
        ipac_pkg::REG_SVC_PORT: svc_port_q  <= pwdata[15:0];
        ipac_pkg::REG_REPEATS:  repeats_q   <= pwdata[15:0];
        ipac_pkg::REG_IPV6_EN:  ipv6_en_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ipac_pkg::REG_KEY_HIGH: prdata = key_high_q;
      ipac_pkg::REG_KEY_LOW:  prdata = key_low_q;
      ipac_pkg::REG_DECIPHER: prdata = {63'd0, decipher_q};
      ipac_pkg::REG_FILTER:   prdata = {62'd0, filt_mode_q};
      ipac_pkg::REG_SVC_PORT: prdata = {48'd0, svc_port_q};
      ipac_pkg::REG_REPEATS:  prdata = {48'd0, repeats_q};
      ipac_pkg::REG_IPV6_EN:  prdata = {63'd0, ipv6_en_q};
      default:                prdata = '0;
    endcase
  end

  // sequencer
  assign in_acc   = in_valid_i && !in_stall_o;
  assign run_done = (step_q == ipac_pkg::STEP_LAST) && (pass_q == repeats_q - 16'd1);
  assign load_out = (state_q == ipac_pkg::ST_HOLD) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ipac_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (repeats_q == 16'd0) ? ipac_pkg::ST_HOLD : ipac_pkg::ST_RUN;
        end
      end
      ipac_pkg::ST_RUN: begin
        if (run_done) begin
          state_d = ipac_pkg::ST_HOLD;
        end
      end
      ipac_pkg::ST_HOLD: begin
        if (load_out) begin
          state_d = ipac_pkg::ST_IDLE;
        end
      end
      default: state_d = ipac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ipac_pkg::ST_IDLE);
    step_d     = step_q;
    pass_d     = pass_q;
    if (in_acc) begin
      step_d = 2'd0;
      pass_d = 16'd0;
    end else if (state_q == ipac_pkg::ST_RUN) begin
      if (step_q == ipac_pkg::STEP_LAST) begin
        step_d = 2'd0;
        pass_d = pass_q + 16'd1;
      end else begin
        step_d = step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipac_pkg::ST_IDLE;
      step_q  <= 2'd0;
      pass_q  <= 16'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
    end
  end

  // lanes: per address, hi word, hi low word, lo word, lo low word
  assign kw[0] = key_high_q[63:32];
  assign kw[1] = key_high_q[31:0];
  assign kw[2] = key_low_q[63:32];
  assign kw[3] = key_low_q[31:0];

  always_comb begin
    lane_ctrl.load      = in_acc;
    lane_ctrl.en        = (state_q == ipac_pkg::ST_RUN);
    lane_ctrl.decipher  = decipher_q;
    lane_ctrl.last      = (step_q == ipac_pkg::STEP_LAST);
    lane_ctrl.key_round = decipher_q ? kw[2'd3 - step_q] : kw[step_q];
    lane_ctrl.key_final = decipher_q ? kw[0] : kw[3];
    lane_in[0] = in_req_i.src_addr_high[63:32];
    lane_in[1] = in_req_i.src_addr_high[31:0];
    lane_in[2] = in_req_i.src_addr_low[63:32];
    lane_in[3] = in_req_i.src_addr_low[31:0];
    lane_in[4] = in_req_i.dst_addr_high[63:32];
    lane_in[5] = in_req_i.dst_addr_high[31:0];
    lane_in[6] = in_req_i.dst_addr_low[63:32];
    lane_in[7] = in_req_i.dst_addr_low[31:0];
  end

  for (genvar g = 0; g < ipac_pkg::LANES; g++) begin : g_lane
    ipac_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (lane_ctrl),
      .blk_i  (lane_in[g]),
      .blk_o  (lane_out[g])
    );
  end

  assign filt.mode         = filt_mode_q;
  assign filt.service_port = svc_port_q;
  assign filt.ipv6_en      = ipv6_en_q;

  ipac_merge u_merge (
    .req_i   (req_q),
    .filt_i  (filt),
    .lanes_i (lane_out),
    .rsp_o   (merged)
  );

  // response register
  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_rsp_q <= merged;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  a_acc_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != ipac_pkg::ST_IDLE)
    else $error("request accepted but core stayed idle");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ipac_pkg::ST_RUN |-> (pass_q < repeats_q) && (step_q <= ipac_pkg::STEP_LAST))
    else $error("round counters out of range");

  a_out_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ipac_pkg::ST_HOLD)
    else $error("response raised outside merge cycle");
`endif

endmodule

`default_nettype wire

// ===== bench/ip_address_cipher_filter_test.sv =====
`timescale 1ns / 100ps

module ip_address_cipher_filter_test;

  localparam logic [1:0] FAM_OTHER = 2'd0;
  localparam logic [1:0] FAM_IPV4  = ipac_pkg::FAM_IPV4;
  localparam logic [1:0] FAM_IPV6  = ipac_pkg::FAM_IPV6;
  localparam logic [1:0] FAM_RSVD  = 2'd3;

  localparam logic [1:0] FILTER_ALL    = 2'd0;
  localparam logic [1:0] FILTER_CLIENT = 2'd1;
  localparam logic [1:0] FILTER_SERVER = 2'd2;
  localparam logic [1:0] FILTER_BOTH   = 2'd3;

  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 192;

  localparam logic [63:0] ONES = '1;
  localparam logic [63:0] PAT_A = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] PAT_B = 64'hfedc_ba98_7654_3210;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic        decipher;
    logic [1:0]  filter;
    logic [15:0] svc_port;
    logic [15:0] repeats;
    logic        ipv6_en;
  } cfg_t;

  typedef struct packed {
    logic        chg;
    logic [63:0] hi;
    logic [63:0] lo;
  } addr_result_t;

  typedef struct {
    cfg_t           cfg;
    ipac_pkg::req_t req;
    bit             typed;
    bit             src_chg;
    bit             dst_chg;
  } vector_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  ipac_pkg::req_t in_req_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  ipac_pkg::rsp_t out_rsp_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ipac_pkg::ADDR_W-1:0] paddr = '0;
  logic [ipac_pkg::DATA_W-1:0] pwdata = '0;
  logic [ipac_pkg::DATA_W-1:0] prdata;
  logic        pready;

  cfg_t        cur_cfg;
  ipac_pkg::rsp_t expected_rsp_q[$];
  vector_t     vectors[$];
  int          errors = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  ip_address_cipher_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- cipher predictor ----------------

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [31:0] scramble_fwd(input logic [31:0] w);
    logic [7:0] a, b, c, d;
    {a, b, c, d} = w;
    a = a + b;
    c = c + d;
    b = rotl8(b, 2) ^ a;
    d = rotl8(d, 5) ^ c;
    a = rotl8(a, 4) + d;
    c = c + b;
    b = rotl8(b, 3) ^ c;
    d = rotl8(d, 7) ^ a;
    c = rotl8(c, 4);
    return {a, b, c, d};
  endfunction

  function automatic logic [31:0] scramble_bwd(input logic [31:0] w);
    logic [7:0] a, b, c, d;
    {a, b, c, d} = w;
    c = rotl8(c, 4);
    b = b ^ c;
    d = d ^ a;
    b = rotl8(b, 5);
    d = rotl8(d, 1);
    a = a - d;
    c = c - b;
    a = rotl8(a, 4);
    b = b ^ a;
    d = d ^ c;
    b = rotl8(b, 6);
    d = rotl8(d, 3);
    a = a - b;
    c = c - d;
    return {a, b, c, d};
  endfunction

  function automatic logic [31:0] ipcrypt_block(input logic [31:0] w);
    logic [31:0] k0, k1, k2, k3, s;
    k0 = cur_cfg.key_high[63:32];
    k1 = cur_cfg.key_high[31:0];
    k2 = cur_cfg.key_low[63:32];
    k3 = cur_cfg.key_low[31:0];
    s = w;
    for (int n = 0; n < int'(cur_cfg.repeats); n++) begin
      if (cur_cfg.decipher) begin
        s = scramble_bwd(s ^ k3);
        s = scramble_bwd(s ^ k2);
        s = scramble_bwd(s ^ k1);
        s = s ^ k0;
      end else begin
        s = scramble_fwd(s ^ k0);
        s = scramble_fwd(s ^ k1);
        s = scramble_fwd(s ^ k2);
        s = s ^ k3;
      end
    end
    return s;
  endfunction

  function automatic addr_result_t transform_addr(input logic [1:0] fam, input logic [63:0] hi,
                                                  input logic [63:0] lo, input logic [15:0] port);
    addr_result_t res;
    bit skip;
    skip = (cur_cfg.filter[0] && port == cur_cfg.svc_port) ||
           (cur_cfg.filter[1] && port != cur_cfg.svc_port);
    res.chg = 1'b0;
    res.hi = hi;
    res.lo = lo;
    if (!skip) begin
      if (fam == FAM_IPV4) begin
        res.lo[31:0] = ipcrypt_block(lo[31:0]);
        res.chg = 1'b1;
      end else if (fam == FAM_IPV6 && cur_cfg.ipv6_en) begin
        res.hi = {ipcrypt_block(hi[63:32]), ipcrypt_block(hi[31:0])};
        res.lo = {ipcrypt_block(lo[63:32]), ipcrypt_block(lo[31:0])};
        res.chg = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic ipac_pkg::rsp_t predict_rsp(input ipac_pkg::req_t r);
    ipac_pkg::rsp_t p;
    addr_result_t a;
    a = transform_addr(r.src_family, r.src_addr_high, r.src_addr_low, r.src_port);
    p.src_changed = a.chg;
    p.src_out_high = a.hi;
    p.src_out_low = a.lo;
    a = transform_addr(r.dst_family, r.dst_addr_high, r.dst_addr_low, r.dst_port);
    p.dst_changed = a.chg;
    p.dst_out_high = a.hi;
    p.dst_out_low = a.lo;
    return p;
  endfunction

  // addresses pass through, only the flags are given
  function automatic ipac_pkg::rsp_t same_rsp(input ipac_pkg::req_t r, input bit sc,
                                              input bit dc);
    ipac_pkg::rsp_t p;
    p.src_changed = sc;
    p.src_out_high = r.src_addr_high;
    p.src_out_low = r.src_addr_low;
    p.dst_changed = dc;
    p.dst_out_high = r.dst_addr_high;
    p.dst_out_low = r.dst_addr_low;
    return p;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic ipac_pkg::req_t mk_req(input logic [1:0] sf, input logic [63:0] sh,
                                            input logic [63:0] sl, input logic [15:0] sp,
                                            input logic [1:0] df, input logic [63:0] dh,
                                            input logic [63:0] dl, input logic [15:0] dp);
    ipac_pkg::req_t r;
    r.src_family = sf;
    r.src_addr_high = sh;
    r.src_addr_low = sl;
    r.src_port = sp;
    r.dst_family = df;
    r.dst_addr_high = dh;
    r.dst_addr_low = dl;
    r.dst_port = dp;
    return r;
  endfunction

  function automatic cfg_t mk_cfg(input logic [63:0] kh, input logic [63:0] kl, input logic dec,
                                  input logic [1:0] filt, input logic [15:0] svc,
                                  input logic [15:0] reps, input logic v6);
    cfg_t c;
    c.key_high = kh;
    c.key_low = kl;
    c.decipher = dec;
    c.filter = filt;
    c.svc_port = svc;
    c.repeats = reps;
    c.ipv6_en = v6;
    return c;
  endfunction

  function automatic logic [63:0] rand_word64();
    int pick;
    pick = $urandom_range(99);
    if (pick < 6) return '0;
    if (pick < 12) return ONES;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [15:0] rand_port();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return cur_cfg.svc_port;
    if (pick < 45) return 16'h0000;
    if (pick < 50) return 16'hffff;
    if (pick < 55) return cur_cfg.svc_port ^ 16'h0001;
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [1:0] rand_family();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return FAM_OTHER;
    if (pick == 1) return FAM_RSVD;
    if (pick < 6) return FAM_IPV4;
    return FAM_IPV6;
  endfunction

  function automatic ipac_pkg::req_t rand_req();
    return mk_req(rand_family(), rand_word64(), rand_word64(), rand_port(),
                  rand_family(), rand_word64(), rand_word64(), rand_port());
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    int pick;
    c.key_high = rand_word64();
    c.key_low = rand_word64();
    c.decipher = 1'($urandom_range(1));
    pick = $urandom_range(99);
    c.filter = pick < 40 ? FILTER_ALL : pick < 65 ? FILTER_CLIENT :
               pick < 90 ? FILTER_SERVER : FILTER_BOTH;
    pick = $urandom_range(99);
    c.svc_port = pick < 10 ? 16'd1 : pick < 20 ? 16'hffff :
                 pick < 40 ? ipac_pkg::SVC_PORT_RST : 16'($urandom_range(1, 65535));
    pick = $urandom_range(99);
    c.repeats = pick < 60 ? 16'($urandom_range(1, 3)) : pick < 85 ? 16'($urandom_range(4, 16)) :
                pick < 92 ? 16'd0 : 16'($urandom_range(17, 150));
    c.ipv6_en = $urandom_range(99) < 80;
    return c;
  endfunction

  // ---------------- drivers ----------------

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_cfg(input cfg_t c);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_write(ipac_pkg::REG_KEY_HIGH, c.key_high);
    cfg_write(ipac_pkg::REG_KEY_LOW, c.key_low);
    cfg_write(ipac_pkg::REG_DECIPHER, {63'd0, c.decipher});
    cfg_write(ipac_pkg::REG_FILTER, {62'd0, c.filter});
    cfg_write(ipac_pkg::REG_SVC_PORT, {48'd0, c.svc_port});
    cfg_write(ipac_pkg::REG_REPEATS, {48'd0, c.repeats});
    cfg_write(ipac_pkg::REG_IPV6_EN, {63'd0, c.ipv6_en});
    cur_cfg = c;
  endtask

  task automatic send_req(input ipac_pkg::req_t r, input bit typed, input ipac_pkg::rsp_t fixed);
    int gap;
    if (!calm && $urandom_range(99) < 23) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req_i <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_rsp_q.push_back(typed ? fixed : predict_rsp(r));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || calm) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < 23);
  end

  // ---------------- response check ----------------

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : response_check
    ipac_pkg::rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual %h", $time, out_rsp_o);
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("src_changed", want.src_changed, out_rsp_o.src_changed);
        check_field("src_out_high", want.src_out_high, out_rsp_o.src_out_high);
        check_field("src_out_low", want.src_out_low, out_rsp_o.src_out_low);
        check_field("dst_changed", want.dst_changed, out_rsp_o.dst_changed);
        check_field("dst_out_high", want.dst_out_high, out_rsp_o.dst_out_high);
        check_field("dst_out_low", want.dst_out_low, out_rsp_o.dst_out_low);
      end
    end
  end

  // ---------------- directed table ----------------

  task automatic add_row(input cfg_t c, input ipac_pkg::req_t r, input bit typed, input bit sc,
                         input bit dc);
    vector_t v;
    v.cfg = c;
    v.req = r;
    v.typed = typed;
    v.src_chg = sc;
    v.dst_chg = dc;
    vectors.push_back(v);
  endtask

  task automatic build_table();
    cfg_t rc, ca, cb, cc, cd, ce, cf, cg, ch, ci;
    rc = mk_cfg('0, '0, 1'b0, FILTER_ALL, ipac_pkg::SVC_PORT_RST, ipac_pkg::REPEATS_RST, 1'b0);
    ca = mk_cfg(ONES, ONES, 1'b0, FILTER_ALL, ipac_pkg::SVC_PORT_RST, 16'd1, 1'b1);
    cb = mk_cfg(ONES, ONES, 1'b1, FILTER_ALL, ipac_pkg::SVC_PORT_RST, 16'd1, 1'b1);
    cc = mk_cfg(PAT_A, PAT_B, 1'b0, FILTER_CLIENT, ipac_pkg::SVC_PORT_RST, 16'd1, 1'b1);
    cd = mk_cfg(PAT_B, PAT_A, 1'b1, FILTER_SERVER, 16'hffff, 16'd1, 1'b1);
    ce = mk_cfg(PAT_A, PAT_B, 1'b0, FILTER_BOTH, 16'd1, 16'd1, 1'b1);
    cf = mk_cfg(PAT_A, PAT_B, 1'b0, FILTER_ALL, ipac_pkg::SVC_PORT_RST, 16'd0, 1'b1);
    cg = mk_cfg(PAT_B, PAT_A, 1'b0, FILTER_ALL, ipac_pkg::SVC_PORT_RST, 16'hffff, 1'b1);
    ch = mk_cfg(PAT_A, ONES, 1'b1, FILTER_ALL, ipac_pkg::SVC_PORT_RST, 16'd2, 1'b1);
    ci = mk_cfg('0, '0, 1'b1, FILTER_ALL, ipac_pkg::SVC_PORT_RST, 16'd7, 1'b0);
    // reset settings: other families, IPv6 disabled, IPv4 extremes
    add_row(rc, mk_req(FAM_OTHER, ONES, ONES, 16'hffff, FAM_RSVD, ONES, ONES, 16'd0), 1, 0, 0);
    add_row(rc, mk_req(FAM_IPV6, PAT_A, PAT_B, 16'd53, FAM_IPV6, '0, '0, 16'd0), 1, 0, 0);
    add_row(rc, mk_req(FAM_IPV4, ONES, ONES, 16'd0, FAM_IPV4, '0, '0, 16'hffff), 0, 0, 0);
    add_row(rc, mk_req(FAM_IPV4, PAT_A, 64'h1234_5678, 16'd53, FAM_OTHER, PAT_B, PAT_A, 16'd1),
            0, 0, 0);
    add_row(ca, mk_req(FAM_IPV6, ONES, ONES, 16'd0, FAM_IPV6, '0, '0, 16'hffff), 0, 0, 0);
    add_row(ca, mk_req(FAM_IPV6, PAT_A, PAT_B, 16'd80, FAM_IPV4, PAT_B, PAT_A, 16'd443), 0, 0, 0);
    add_row(ca, mk_req(FAM_RSVD, PAT_A, PAT_B, 16'd0, FAM_IPV6, PAT_B, PAT_A, 16'd0), 0, 0, 0);
    add_row(cb, mk_req(FAM_IPV6, ONES, ONES, 16'd0, FAM_IPV4, '0, '0, 16'd0), 0, 0, 0);
    add_row(cb, mk_req(FAM_IPV4, PAT_A, PAT_B, 16'd9, FAM_IPV6, PAT_B, PAT_A, 16'd9), 0, 0, 0);
    // client filter skips the service port
    add_row(cc, mk_req(FAM_IPV4, PAT_A, PAT_B, 16'd53, FAM_IPV6, PAT_B, PAT_A, 16'd53), 1, 0, 0);
    add_row(cc, mk_req(FAM_IPV4, PAT_A, PAT_B, 16'd0, FAM_IPV6, PAT_B, PAT_A, 16'hffff), 0, 0, 0);
    // server filter skips everything else
    add_row(cd, mk_req(FAM_IPV4, PAT_A, PAT_B, 16'hffff, FAM_IPV4, PAT_B, PAT_A, 16'hfffe),
            0, 0, 0);
    add_row(cd, mk_req(FAM_IPV6, PAT_A, PAT_B, 16'd0, FAM_IPV4, PAT_B, PAT_A, 16'd1), 1, 0, 0);
    // both filters: nothing passes
    add_row(ce, mk_req(FAM_IPV4, PAT_A, PAT_B, 16'd1, FAM_IPV6, PAT_B, PAT_A, 16'd2), 1, 0, 0);
    // zero passes: flagged but unchanged
    add_row(cf, mk_req(FAM_IPV4, PAT_A, PAT_B, 16'd53, FAM_IPV6, PAT_B, PAT_A, 16'd0), 1, 1, 1);
    add_row(cf, mk_req(FAM_OTHER, PAT_A, PAT_B, 16'd0, FAM_IPV6, ONES, '0, 16'd5), 1, 0, 1);
    add_row(cg, mk_req(FAM_IPV6, PAT_A, PAT_B, 16'd7, FAM_IPV4, PAT_B, PAT_A, 16'd9), 0, 0, 0);
    add_row(ch, mk_req(FAM_IPV6, PAT_B, PAT_A, 16'd0, FAM_IPV4, ONES, ONES, 16'd0), 0, 0, 0);
    add_row(ci, mk_req(FAM_IPV6, PAT_A, PAT_B, 16'd3, FAM_IPV4, PAT_A, PAT_B, 16'd3), 0, 0, 0);
  endtask

  // ---------------- sequence ----------------

  initial begin
    cfg_t c;
    cur_cfg = mk_cfg('0, '0, 1'b0, FILTER_ALL, ipac_pkg::SVC_PORT_RST, ipac_pkg::REPEATS_RST,
                     1'b0);
    build_table();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vectors[i]) begin
      if (vectors[i].cfg != cur_cfg) apply_cfg(vectors[i].cfg);
      send_req(vectors[i].req, vectors[i].typed,
               same_rsp(vectors[i].req, vectors[i].src_chg, vectors[i].dst_chg));
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      c = rand_cfg();
      if (ph == 0) begin
        c.key_high = ONES;
        c.key_low = ONES;
        c.svc_port = 16'hffff;
      end else if (ph == 1) begin
        c.key_high = '0;
        c.key_low = '0;
        c.svc_port = 16'd1;
        c.filter = FILTER_CLIENT;
      end
      calm = 1'b0;
      apply_cfg(c);
      calm = (ph == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) begin
          // hold off until the block is empty
          wait_drained();
          @(posedge clk_i);
        end
        send_req(rand_req(), 1'b0, '0);
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (3 * int'(cur_cfg.repeats) + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ipac_pkg.sv
hdl/ipac_lane.sv
hdl/ipac_merge.sv
hdl/ip_address_cipher_filter.sv
bench/ip_address_cipher_filter_test.sv
